// File: rtl/stream_record_decimator_defines.svh
// Assertion macros used by the checker file srd_checker.sv.
`ifndef STREAM_RECORD_DECIMATOR_DEFINES_SVH
`define STREAM_RECORD_DECIMATOR_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SRD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srd assertion failed");

// Next-cycle implication, disabled in reset.
`define SRD_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srd assertion failed");

`endif

// File: rtl/srd_pkg.sv
`timescale 1ns / 1ps
package srd_pkg;

    localparam int STREAMS   = 4;
    localparam int SLOT_W    = 2;
    localparam int TIME_W    = 48;
    localparam int TAG_W     = 32;
    localparam int REG_W     = 32;
    localparam int GRACE_W   = 33;
    localparam int CFG_IDX_W = 3;

    // floor(x / 5) = (x * DIV5_MUL) >> DIV5_SHIFT for any 32-bit x
    localparam logic [REG_W-1:0] DIV5_MUL   = 32'hCCCC_CCCD;
    localparam int               DIV5_SHIFT = 34;

    typedef enum logic [1:0] {
        MODE_RECORD = 2'd0,
        MODE_FLUSH  = 2'd1,
        MODE_CLEAR  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_VERDICT = 2'd0,
        KIND_SUBMIT  = 2'd1,
        KIND_CLOSE   = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASK   = 3'd0,
        CFG_IVAL0  = 3'd1,
        CFG_IVAL1  = 3'd2,
        CFG_IVAL2  = 3'd3,
        CFG_IVAL3  = 3'd4,
        CFG_BUCKET = 3'd5,
        CFG_DELTA  = 3'd6
    } cfg_idx_t;

    // results still owed for one request
    typedef struct packed {
        logic [STREAMS-1:0] cand;
        logic               close;
        logic               close_last;
        logic               verdict;
        logic               verdict_taken;
    } burst_t;

endpackage

// File: rtl/stream_record_decimator.sv
`timescale 1ns / 1ps
// Path: input register, then result sequencer, then output register.
// Throughput: one request per cycle when it gives one result and out_ready holds; a
// request with more results (bucket candidates, close, verdict) blocks till all are out.
// Reset: rst_n clears config, valid and handshake state at once, no clearing pass.
module stream_record_decimator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic                          is_data_record,
    input  logic [srd_pkg::SLOT_W-1:0]    stream_slot,
    input  logic [srd_pkg::TIME_W-1:0]    timestamp,
    input  logic [srd_pkg::TAG_W-1:0]     record_tag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    kind,
    output logic                          taken,
    output logic [srd_pkg::SLOT_W-1:0]    out_slot,
    output logic [srd_pkg::TAG_W-1:0]     out_tag,
    output logic [srd_pkg::TIME_W-1:0]    out_time,
    output logic [srd_pkg::GRACE_W-1:0]   grace_window,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic [srd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srd_pkg::REG_W-1:0]     cfg_data
);
    import srd_pkg::*;

    // configuration
    logic [STREAMS-1:0] mask_reg;
    logic [REG_W-1:0]   ival_reg [STREAMS];
    logic [REG_W-1:0]   bucket_reg;
    logic [REG_W-1:0]   delta_reg;
    logic [GRACE_W-1:0] grace_reg;
    logic [GRACE_W-1:0] grace_next;
    logic [2*REG_W-1:0] div_prod;

    // input stage
    logic               in_v_reg;
    logic [1:0]         mode_reg;
    logic               data_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [TIME_W-1:0]  ts_reg;
    logic [TAG_W-1:0]   tag_reg;

    // decimation state
    logic [STREAMS-1:0] cur_v_reg;
    logic [STREAMS-1:0] cur_v_next;
    logic [TIME_W-1:0]  cur_time_reg [STREAMS];
    logic               ctr_v_reg;
    logic               ctr_v_next;
    logic [TIME_W-1:0]  ctr_time_reg;
    logic [TIME_W-1:0]  ctr_time_next;
    logic [STREAMS-1:0] cand_v_reg;
    logic [STREAMS-1:0] cand_v_next;
    logic [TAG_W-1:0]   cand_tag_reg [STREAMS];
    logic [TIME_W-1:0]  cand_time_reg [STREAMS];
    logic               cand_wr;
    logic               cur_wr;

    // result sequencer
    burst_t             pend_reg;
    burst_t             pend_after;
    burst_t             load;
    logic [TIME_W-1:0]  max_reg;
    logic [TIME_W-1:0]  max_next;

    // output register
    logic               out_v_reg;
    kind_t              kind_reg;
    kind_t              kind_next;
    logic               taken_reg;
    logic               taken_next;
    logic [SLOT_W-1:0]  slot_out_reg;
    logic [SLOT_W-1:0]  slot_out_next;
    logic [TAG_W-1:0]   tag_out_reg;
    logic [TAG_W-1:0]   tag_out_next;
    logic [TIME_W-1:0]  time_out_reg;
    logic [TIME_W-1:0]  time_out_next;
    logic [GRACE_W-1:0] grace_out_reg;
    logic [GRACE_W-1:0] grace_out_next;
    logic               last_reg;
    logic               last_next;

    // datapath
    logic               slot_ok;
    logic [TIME_W:0]    cur_sum;
    logic               cur_hit;
    logic [TIME_W-1:0]  ctr_eff;
    logic [TIME_W:0]    ctr_sum;
    logic [TIME_W-1:0]  ctr_adv;
    logic [TIME_W-1:0]  d_new;
    logic [TIME_W-1:0]  d_old;
    logic               beyond;
    logic               in_window;
    logic               closer;

    logic               pend_any;
    logic               emit_go;
    logic               burst_free;
    logic               proc_go;
    logic               pick_found;
    logic [SLOT_W-1:0]  pick;

    // grace = interval + floor(interval / 5)
    assign div_prod   = bucket_reg * DIV5_MUL;
    assign grace_next = GRACE_W'(bucket_reg) + GRACE_W'(div_prod >> DIV5_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= '0;
            ival_reg   <= '{default: '0};
            bucket_reg <= '0;
            delta_reg  <= '0;
            grace_reg  <= '0;
        end
        else
        begin
            grace_reg <= grace_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MASK:   mask_reg    <= cfg_data[STREAMS-1:0];
                    CFG_IVAL0:  ival_reg[0] <= cfg_data;
                    CFG_IVAL1:  ival_reg[1] <= cfg_data;
                    CFG_IVAL2:  ival_reg[2] <= cfg_data;
                    CFG_IVAL3:  ival_reg[3] <= cfg_data;
                    CFG_BUCKET: bucket_reg  <= cfg_data;
                    CFG_DELTA:  delta_reg   <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    // decision datapath
    assign slot_ok   = (int'(slot_reg) < STREAMS);
    assign cur_sum   = {1'b0, cur_time_reg[slot_reg]} + (TIME_W+1)'(ival_reg[slot_reg]);
    assign cur_hit   = cur_v_reg[slot_reg] && ({1'b0, ts_reg} < cur_sum);
    assign ctr_eff   = ctr_v_reg ? ctr_time_reg : ts_reg;
    assign ctr_sum   = {1'b0, ctr_eff} + (TIME_W+1)'(bucket_reg);
    assign ctr_adv   = ctr_sum[TIME_W] ? '1 : ctr_sum[TIME_W-1:0];
    assign d_new     = (ts_reg >= ctr_eff) ? ts_reg - ctr_eff : ctr_eff - ts_reg;
    assign d_old     = (cand_time_reg[slot_reg] >= ctr_eff) ?
                       cand_time_reg[slot_reg] - ctr_eff : ctr_eff - cand_time_reg[slot_reg];
    assign beyond    = (ts_reg > ctr_eff) && (d_new > TIME_W'(delta_reg));
    assign in_window = (d_new <= TIME_W'(delta_reg));
    assign closer    = !cand_v_reg[slot_reg] || (d_new < d_old);

    always_comb
    begin
        load          = '0;
        cur_v_next    = cur_v_reg;
        cur_wr        = 1'b0;
        ctr_v_next    = ctr_v_reg;
        ctr_time_next = ctr_time_reg;
        cand_v_next   = cand_v_reg;
        cand_wr       = 1'b0;
        case (mode_reg)
            MODE_CLEAR:
            begin
                cur_v_next  = '0;
                ctr_v_next  = 1'b0;
                cand_v_next = '0;
            end
            MODE_FLUSH:
            begin
                if (bucket_reg != '0)
                begin
                    load.cand       = cand_v_reg;
                    load.close      = 1'b1;
                    load.close_last = 1'b1;
                    cand_v_next     = '0;
                end
            end
            MODE_RECORD:
            begin
                load.verdict = 1'b1;
                if (data_reg && slot_ok)
                begin
                    if (mask_reg != '0)
                    begin
                        if (mask_reg[slot_reg])
                        begin
                            if (cur_hit)
                            begin
                                load.verdict_taken = 1'b1;
                            end
                            else
                            begin
                                cur_v_next[slot_reg] = 1'b1;
                                cur_wr               = 1'b1;
                            end
                        end
                    end
                    else if (bucket_reg != '0)
                    begin
                        load.verdict_taken = 1'b1;
                        ctr_v_next         = 1'b1;
                        if (beyond)
                        begin
                            load.cand     = cand_v_reg;
                            load.close    = 1'b1;
                            cand_v_next   = '0;
                            ctr_time_next = ctr_adv;
                        end
                        else
                        begin
                            ctr_time_next = ctr_eff;
                            if (in_window && closer)
                            begin
                                cand_v_next[slot_reg] = 1'b1;
                                cand_wr               = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // result sequencer: candidates in slot order, then close, then verdict
    assign pend_any = (pend_reg.cand != '0) || pend_reg.close || pend_reg.verdict;
    assign emit_go  = pend_any && (!out_v_reg || out_ready);

    always_comb
    begin
        pick_found = 1'b0;
        pick       = '0;
        for (int s = STREAMS - 1; s >= 0; s--)
        begin
            if (pend_reg.cand[s])
            begin
                pick_found = 1'b1;
                pick       = SLOT_W'(s);
            end
        end
    end

    always_comb
    begin
        pend_after     = pend_reg;
        max_next       = max_reg;
        kind_next      = KIND_VERDICT;
        taken_next     = 1'b0;
        slot_out_next  = '0;
        tag_out_next   = '0;
        time_out_next  = '0;
        grace_out_next = '0;
        last_next      = 1'b0;
        if (pick_found)
        begin
            pend_after.cand[pick] = 1'b0;
            kind_next             = KIND_SUBMIT;
            slot_out_next         = pick;
            tag_out_next          = cand_tag_reg[pick];
            time_out_next         = cand_time_reg[pick];
            if (cand_time_reg[pick] > max_reg)
            begin
                max_next = cand_time_reg[pick];
            end
        end
        else if (pend_reg.close)
        begin
            pend_after.close = 1'b0;
            kind_next        = KIND_CLOSE;
            time_out_next    = max_reg;
            grace_out_next   = grace_reg;
            last_next        = pend_reg.close_last;
        end
        else
        begin
            pend_after.verdict = 1'b0;
            taken_next         = pend_reg.verdict_taken;
            last_next          = 1'b1;
        end
    end

    assign burst_free = !pend_any ||
                        (emit_go && (pend_after.cand == '0) && !pend_after.close &&
                         !pend_after.verdict);
    assign proc_go    = in_v_reg && burst_free;
    assign in_ready   = !in_v_reg || proc_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            cur_v_reg  <= '0;
            ctr_v_reg  <= 1'b0;
            cand_v_reg <= '0;
            pend_reg   <= '0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_v_reg <= in_valid;
            end
            if (proc_go)
            begin
                cur_v_reg  <= cur_v_next;
                ctr_v_reg  <= ctr_v_next;
                cand_v_reg <= cand_v_next;
                pend_reg   <= load;
            end
            else if (emit_go)
            begin
                pend_reg <= pend_after;
            end
            if (emit_go)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= mode;
            data_reg <= is_data_record;
            slot_reg <= stream_slot;
            ts_reg   <= timestamp;
            tag_reg  <= record_tag;
        end
        if (proc_go)
        begin
            ctr_time_reg <= ctr_time_next;
            max_reg      <= '0;
            if (cur_wr)
            begin
                cur_time_reg[slot_reg] <= ts_reg;
            end
            if (cand_wr)
            begin
                cand_tag_reg[slot_reg]  <= tag_reg;
                cand_time_reg[slot_reg] <= ts_reg;
            end
        end
        else if (emit_go)
        begin
            max_reg <= max_next;
        end
        if (emit_go)
        begin
            kind_reg      <= kind_next;
            taken_reg     <= taken_next;
            slot_out_reg  <= slot_out_next;
            tag_out_reg   <= tag_out_next;
            time_out_reg  <= time_out_next;
            grace_out_reg <= grace_out_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid    = out_v_reg;
    assign kind         = kind_reg;
    assign taken        = taken_reg;
    assign out_slot     = slot_out_reg;
    assign out_tag      = tag_out_reg;
    assign out_time     = time_out_reg;
    assign grace_window = grace_out_reg;
    assign last         = last_reg;

endmodule

// File: rtl/srd_checker.sv
`timescale 1ns / 1ps
`include "stream_record_decimator_defines.svh"
module srd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [1:0]                  kind,
    input logic                        taken,
    input logic [srd_pkg::SLOT_W-1:0]  out_slot,
    input logic [srd_pkg::TAG_W-1:0]   out_tag,
    input logic [srd_pkg::TIME_W-1:0]  out_time,
    input logic [srd_pkg::GRACE_W-1:0] grace_window,
    input logic                        last
);
    import srd_pkg::*;

    `SRD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(out_tag) && $stable(out_time))
    `SRD_ASSERT_IMP(a_verdict_shape, out_valid && kind == KIND_VERDICT, last && out_tag == '0 && out_time == '0 && grace_window == '0 && out_slot == '0)
    `SRD_ASSERT_IMP(a_submit_shape, out_valid && kind == KIND_SUBMIT, !last && !taken && grace_window == '0)
    `SRD_ASSERT_IMP(a_close_shape, out_valid && kind == KIND_CLOSE, !taken && out_tag == '0 && out_slot == '0)
    `SRD_ASSERT_NXT(a_submit_then_close, out_valid && out_ready && kind == KIND_SUBMIT, !out_valid || kind != KIND_VERDICT)

endmodule

bind stream_record_decimator srd_checker u_srd_checker (.*);
